// ===== rtl/fkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fkc_pkg: shared types and constants of the key cache
// Request and response items, the search token that walks the cell chain,
// and the update broadcast that commits an insert.
// ----------------------------------------------------------------------------
package fkc_pkg;

  localparam int KEY_W   = 64;  // width of the key field of an item
  localparam int SLOT_W  = 4;   // width of the slot field of a result
  localparam int AGE_W   = 4;
  localparam int IDX_W   = 6;   // slot index inside the chain, covers up to 64 cells

  localparam logic [AGE_W-1:0] AGE_TOP = 4'hF;

  // operation codes of an item
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
  } rsp_t;

  // running search state handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
    logic             have_min;
    logic [AGE_W-1:0] min_age;
    logic [IDX_W-1:0] min_idx;
  } token_t;

  // insert commit broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] victim;
  } upd_t;

endpackage : fkc_pkg
`default_nettype wire

// ===== rtl/fkc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fkc_cell: one slot of the key cache
// Holds valid, key and age of one slot, folds its contribution into the
// passing search token and registers the token toward the next cell.
// ----------------------------------------------------------------------------
module fkc_cell #(
  parameter int INDEX    = 0,
  parameter int KEY_BITS = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [KEY_BITS-1:0]   key_i,
  input  fkc_pkg::token_t       tok_i,
  output fkc_pkg::token_t       tok_o,
  input  fkc_pkg::upd_t         upd_i
);
  import fkc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                valid_q;
  logic [AGE_W-1:0]    age_q;
  logic [KEY_BITS-1:0] key_q;
  token_t              tok_d, tok_q;
  logic                match;
  logic                is_victim;

  assign match     = valid_q && (key_q == key_i);
  assign is_victim = upd_i.en && (upd_i.victim == MY_IDX);

  // fold this slot into the running search
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (!tok_i.found && match) begin
        tok_d.found     = 1'b1;
        tok_d.found_idx = MY_IDX;
      end
      if (!tok_i.empty_found && !valid_q) begin
        tok_d.empty_found = 1'b1;
        tok_d.empty_idx   = MY_IDX;
      end
      if (!tok_i.have_min || (age_q < tok_i.min_age)) begin
        tok_d.have_min = 1'b1;
        tok_d.min_age  = age_q;
        tok_d.min_idx  = MY_IDX;
      end
    end
  end

  // advance the token to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // commit an insert: take the key or age by one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (upd_i.en) begin
      if (is_victim) begin
        valid_q <= 1'b1;
        age_q   <= AGE_TOP;
      end else if (valid_q && (age_q != '0)) begin
        age_q <= age_q - 1'b1;
      end
    end
  end

  // hold the key, no reset needed
  always_ff @(posedge clk_i) begin
    if (is_victim) begin
      key_q <= key_i;
    end
  end

endmodule : fkc_cell
`default_nettype wire

// ===== rtl/fifo_replacement_key_cache_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_replacement_key_cache_top: fully associative key cache, FIFO eviction
// An item's search token walks a chain of ENTRIES slot cells, one per cycle;
// the result is formed at the chain end and an insert commits to all cells.
// Result: done_o and rsp_o are registered from the token at the chain end.
// Busy stays high while a token is in the cell chain; a new item is taken
// once the prior one is at the chain end. The receiver cannot stall results.
// Reset: all slots empty with age zero, no item in flight.
// ----------------------------------------------------------------------------
module fifo_replacement_key_cache_top #(
  parameter int ENTRIES  = 10,
  parameter int KEY_BITS = 64
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  fkc_pkg::req_t  req_i,
  output logic           done_o,
  output fkc_pkg::rsp_t  rsp_o
);
  import fkc_pkg::*;

  token_t              chain [ENTRIES+1];
  logic [ENTRIES:0]    chain_vld;
  token_t              tok0_d, tok0_q;
  logic [KEY_BITS-1:0] key_q;
  token_t              fin;
  upd_t                upd;
  rsp_t                rsp_d, rsp_q;
  logic                done_q;
  logic                accept;

  assign accept   = start && !busy;
  assign chain[0] = tok0_q;

  // build a fresh token for the item taken at this edge
  always_comb begin
    tok0_d       = '0;
    tok0_d.valid = accept;
    tok0_d.kind  = req_i.kind;
  end

  // inject the token on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  // hold the key while the item walks the chain
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= req_i.key[KEY_BITS-1:0];
    end
  end

  // row of slot cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    fkc_cell #(
      .INDEX   (g),
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .key_i (key_q),
      .tok_i (chain[g]),
      .tok_o (chain[g+1]),
      .upd_i (upd)
    );
  end

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
    assign chain_vld[g] = chain[g].valid;
  end

  assign busy = |chain_vld[ENTRIES-1:0];
  assign fin  = chain[ENTRIES];

  // pick the victim and form the result at the chain end
  always_comb begin
    upd.en     = fin.valid && (fin.kind == KIND_INSERT);
    upd.victim = fin.empty_found ? fin.empty_idx : fin.min_idx;
    rsp_d      = '0;
    if (fin.kind == KIND_LOOKUP) begin
      rsp_d.hit  = fin.found;
      rsp_d.slot = fin.found ? fin.found_idx[SLOT_W-1:0] : '0;
    end else begin
      rsp_d.slot     = upd.victim[SLOT_W-1:0];
      rsp_d.replaced = !fin.empty_found;
    end
  end

  // register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.valid) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // only one item walks the chain at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one token in the cell chain");

  // an accepted item sets busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accept");

  // a result strobe follows a token leaving the chain end
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(chain_vld[ENTRIES]))
    else $error("result strobe without a finished token");

  // a lookup hit never reports a replacement
  a_hit_no_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.hit |-> !rsp_o.replaced)
    else $error("hit and replaced both set");

endmodule : fifo_replacement_key_cache_top
`default_nettype wire
